### rtl/stt_pkg.sv
// Package: token kinds, error codes, lexer modes and word types for the tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package stt_pkg;

    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_EQUALS = 6'd1;
    localparam logic [5:0] K_MINUS  = 6'd6;
    localparam logic [5:0] K_DEQ    = 6'd18;
    localparam logic [5:0] K_ARROW  = 6'd19;
    localparam logic [5:0] K_STRING = 6'd20;
    localparam logic [5:0] K_NUMBER = 6'd21;
    localparam logic [5:0] K_IDENT  = 6'd22;
    localparam logic [5:0] K_KW0    = 6'd23;
    localparam logic [5:0] K_ERROR  = 6'd34;

    localparam logic [2:0] E_NONE   = 3'd0;
    localparam logic [2:0] E_STRING = 3'd1;
    localparam logic [2:0] E_HEX    = 3'd2;
    localparam logic [2:0] E_BIN    = 3'd3;
    localparam logic [2:0] E_OCT    = 3'd4;
    localparam logic [2:0] E_CHAR   = 3'd5;

    localparam int NUM_KW = 11;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_file;
    } in_word_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [63:0] number_value;
        logic [31:0] text_start;
        logic [31:0] text_length;
        logic [2:0]  error_code;
        logic        last_of_run;
    } out_word_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_file;
        logic       is_space;
        logic       is_digit;
        logic       is_alpha;
        logic       is_word;
        logic [4:0] hex_val;   // 16 when not a hex digit
        logic [4:0] punct;     // 0 when not a plain punctuator, else kind
    } class_t;

    typedef enum logic [13:0] {
        M_IDLE  = 14'b00000000000001,
        M_STR   = 14'b00000000000010,
        M_ZERO  = 14'b00000000000100,
        M_DEC   = 14'b00000000001000,
        M_HEX0  = 14'b00000000010000,
        M_HEX   = 14'b00000000100000,
        M_BIN0  = 14'b00000001000000,
        M_BIN   = 14'b00000010000000,
        M_OCT0  = 14'b00000100000000,
        M_OCT   = 14'b00001000000000,
        M_IDENT = 14'b00010000000000,
        M_EQ    = 14'b00100000000000,
        M_MINUS = 14'b01000000000000,
        M_ERR   = 14'b10000000000000
    } mode_t;

    function automatic logic [4:0] punct_kind(input logic [7:0] b);
        logic [4:0] k;
        begin
            k = 5'd0;
            unique case (b)
                8'h3A: k = 5'd2;
                8'h3B: k = 5'd3;
                8'h2E: k = 5'd4;
                8'h2B: k = 5'd5;
                8'h2A: k = 5'd7;
                8'h2F: k = 5'd8;
                8'h2C: k = 5'd9;
                8'h28: k = 5'd10;
                8'h29: k = 5'd11;
                8'h7B: k = 5'd12;
                8'h7D: k = 5'd13;
                8'h5B: k = 5'd14;
                8'h5D: k = 5'd15;
                8'h3C: k = 5'd16;
                8'h3E: k = 5'd17;
                default: k = 5'd0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [63:0] kw_text(input int k);
        logic [63:0] t;
        begin
            // byte 0 in bits [7:0]
            case (k)
                0:  t = 64'h0000000000726176;
                1:  t = 64'h000000000074656C;
                2:  t = 64'h6E6F6974636E7566;
                3:  t = 64'h00006E7275746572;
                4:  t = 64'h0000000000006669;
                5:  t = 64'h0000000065736C65;
                6:  t = 64'h000000656C696877;
                7:  t = 64'h0000000065757274;
                8:  t = 64'h00000065736C6166;
                9:  t = 64'h000000006C6C756E;
                default: t = 64'h000000006D756E65;
            endcase
            return t;
        end
    endfunction

    function automatic logic [3:0] kw_len(input int k);
        logic [3:0] l;
        begin
            case (k)
                0, 1: l = 4'd3;
                2:    l = 4'd8;
                3:    l = 4'd6;
                4:    l = 4'd2;
                6, 8: l = 4'd5;
                default: l = 4'd4;
            endcase
            return l;
        end
    endfunction

endpackage
`default_nettype wire

### rtl/stt_front.sv
// Front end: input register and byte classification.
`timescale 1ns / 1ps
`default_nettype none
module stt_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire stt_pkg::in_word_t in_data,
    output logic                   cls_valid,
    input  wire logic              cls_ready,
    output stt_pkg::class_t        cls_data
);
    import stt_pkg::*;

    class_t cls_next;
    class_t cls_data_reg;
    logic   cls_valid_reg;
    logic [7:0] b;

    always_comb
    begin
        b = in_data.char_byte;
        cls_next.char_byte   = b;
        cls_next.end_of_file = in_data.end_of_file;
        cls_next.is_space    = (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
        cls_next.is_digit    = (b >= 8'h30 && b <= 8'h39);
        cls_next.is_alpha    = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
        cls_next.is_word     = cls_next.is_alpha || cls_next.is_digit || (b == 8'h5F);
        if (cls_next.is_digit)
            cls_next.hex_val = {1'b0, b[3:0]};
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            cls_next.hex_val = {1'b0, b[3:0]} + 5'd9;
        else
            cls_next.hex_val = 5'd16;
        cls_next.punct = punct_kind(b);
    end

    assign in_ready  = !cls_valid_reg || cls_ready;
    assign cls_valid = cls_valid_reg;
    assign cls_data  = cls_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cls_valid_reg <= 1'b0;
        else if (in_ready)
            cls_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            cls_data_reg <= cls_next;
    end
endmodule
`default_nettype wire

### rtl/stt_back.sv
// Back end: lexer state machine, up to two result words per byte, output queue.
`timescale 1ns / 1ps
`default_nettype none
module stt_back #(
    parameter int OFFSET_BITS   = 32,
    parameter int KEYWORD_BYTES = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cls_valid,
    output logic                  cls_ready,
    input  wire stt_pkg::class_t  cls_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output stt_pkg::out_word_t    out_data
);
    import stt_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
    localparam int KIDX = $clog2(KEYWORD_BYTES);

    mode_t mode_reg, mode_next;
    logic [63:0] acc_reg, acc_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] len_reg, len_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [KEYWORD_BYTES-1:0][7:0] pref_reg, pref_next;

    // two-entry output queue
    out_word_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;

    out_word_t r0, r1, rid, rnum;
    logic [1:0] n;
    logic again;
    logic fire;
    logic [7:0] b;
    logic [63:0] pref_flat;
    logic [5:0] kw_kind;
    logic [OFFSET_BITS-1:0] pos_inc, len_inc;

    function automatic out_word_t mk(input logic [5:0] k, input logic [2:0] e);
        out_word_t w;
        begin
            w = '0;
            w.token_kind = k;
            w.error_code = e;
            return w;
        end
    endfunction

    assign b = cls_data.char_byte;
    assign pos_inc = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + OFFSET_BITS'(1);
    assign len_inc = (len_reg == POS_MAX) ? POS_MAX : len_reg + OFFSET_BITS'(1);

    always_comb
    begin
        pref_flat = '0;
        for (int i = 0; i < 8; i++)
            pref_flat[i*8 +: 8] = pref_reg[i];
        kw_kind = K_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--)
            if (len_reg == OFFSET_BITS'(kw_len(k)) && pref_flat == kw_text(k))
                kw_kind = K_KW0 + 6'(k);
        rid = mk(kw_kind, E_NONE);
        if (kw_kind == K_IDENT)
        begin
            rid.text_start  = 32'(start_reg);
            rid.text_length = 32'(len_reg);
        end
        rnum = mk(K_NUMBER, E_NONE);
        rnum.number_value = acc_reg;
    end

    // one back-end step; queue must have room for two words
    assign fire      = cls_valid && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && out_ready));
    assign cls_ready = fire;

    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        start_next = start_reg;
        len_next   = len_reg;
        pos_next   = pos_inc;
        pref_next  = pref_reg;
        r0 = '0;
        r1 = '0;
        n = 2'd0;
        again = 1'b0;
        if (cls_data.end_of_file)
        begin
            unique case (mode_reg)
                M_STR:   begin r0 = mk(K_ERROR, E_STRING); n = 2'd1; end
                M_HEX0:  begin r0 = mk(K_ERROR, E_HEX); n = 2'd1; end
                M_BIN0:  begin r0 = mk(K_ERROR, E_BIN); n = 2'd1; end
                M_OCT0:  begin r0 = mk(K_ERROR, E_OCT); n = 2'd1; end
                M_ZERO, M_DEC, M_HEX, M_BIN, M_OCT: begin r0 = rnum; n = 2'd1; end
                M_IDENT: begin r0 = rid; n = 2'd1; end
                M_EQ:    begin r0 = mk(K_EQUALS, E_NONE); n = 2'd1; end
                M_MINUS: begin r0 = mk(K_MINUS, E_NONE); n = 2'd1; end
                default: ;
            endcase
            if (n == 2'd0) r0 = mk(K_EOF, E_NONE);
            else r1 = mk(K_EOF, E_NONE);
            n = n + 2'd1;
            mode_next  = M_IDLE;
            acc_next   = '0;
            start_next = '0;
            len_next   = '0;
            pos_next   = '0;
            pref_next  = '0;
        end
        else
        begin
            unique case (mode_reg)
                M_STR:
                    if (b == 8'h22) begin
                        r0 = mk(K_STRING, E_NONE);
                        r0.text_start  = 32'(start_reg);
                        r0.text_length = 32'(len_reg);
                        n = 2'd1;
                        mode_next = M_IDLE;
                    end else
                        len_next = len_inc;
                M_ZERO:
                    if (b == 8'h78 || b == 8'h58) mode_next = M_HEX0;
                    else if (b == 8'h62 || b == 8'h42) mode_next = M_BIN0;
                    else if (b == 8'h6F || b == 8'h4F) mode_next = M_OCT0;
                    else if (cls_data.is_digit) begin
                        mode_next = M_DEC;
                        acc_next = {acc_reg[60:0], 3'b0} + {acc_reg[62:0], 1'b0}
                                   + 64'(cls_data.hex_val);
                    end else begin
                        r0 = rnum; n = 2'd1; mode_next = M_IDLE; again = 1'b1;
                    end
                M_DEC:
                    if (cls_data.is_digit)
                        acc_next = {acc_reg[60:0], 3'b0} + {acc_reg[62:0], 1'b0}
                                   + 64'(cls_data.hex_val);
                    else begin
                        r0 = rnum; n = 2'd1; mode_next = M_IDLE; again = 1'b1;
                    end
                M_HEX0:
                    if (cls_data.hex_val < 5'd16) begin
                        acc_next = 64'(cls_data.hex_val); mode_next = M_HEX;
                    end else begin
                        r0 = mk(K_ERROR, E_HEX); n = 2'd1; mode_next = M_ERR;
                    end
                M_BIN0:
                    if (cls_data.hex_val < 5'd2) begin
                        acc_next = 64'(cls_data.hex_val); mode_next = M_BIN;
                    end else begin
                        r0 = mk(K_ERROR, E_BIN); n = 2'd1; mode_next = M_ERR;
                    end
                M_OCT0:
                    if (cls_data.hex_val < 5'd8) begin
                        acc_next = 64'(cls_data.hex_val); mode_next = M_OCT;
                    end else begin
                        r0 = mk(K_ERROR, E_OCT); n = 2'd1; mode_next = M_ERR;
                    end
                M_HEX:
                    if (cls_data.hex_val < 5'd16)
                        acc_next = {acc_reg[59:0], cls_data.hex_val[3:0]};
                    else begin
                        r0 = rnum; n = 2'd1; mode_next = M_IDLE; again = 1'b1;
                    end
                M_BIN:
                    if (cls_data.hex_val < 5'd2)
                        acc_next = {acc_reg[62:0], cls_data.hex_val[0]};
                    else begin
                        r0 = rnum; n = 2'd1; mode_next = M_IDLE; again = 1'b1;
                    end
                M_OCT:
                    if (cls_data.hex_val < 5'd8)
                        acc_next = {acc_reg[60:0], cls_data.hex_val[2:0]};
                    else begin
                        r0 = rnum; n = 2'd1; mode_next = M_IDLE; again = 1'b1;
                    end
                M_IDENT:
                    if (cls_data.is_word) begin
                        if (len_reg < OFFSET_BITS'(KEYWORD_BYTES))
                            pref_next[len_reg[KIDX-1:0]] = b;
                        len_next = len_inc;
                    end else begin
                        r0 = rid; n = 2'd1; mode_next = M_IDLE; again = 1'b1;
                    end
                M_EQ:
                begin
                    mode_next = M_IDLE; n = 2'd1;
                    if (b == 8'h3D) r0 = mk(K_DEQ, E_NONE);
                    else begin r0 = mk(K_EQUALS, E_NONE); again = 1'b1; end
                end
                M_MINUS:
                begin
                    mode_next = M_IDLE; n = 2'd1;
                    if (b == 8'h3E) r0 = mk(K_ARROW, E_NONE);
                    else begin r0 = mk(K_MINUS, E_NONE); again = 1'b1; end
                end
                M_ERR: ;
                default: again = 1'b1;   // idle
            endcase

            if (again && !cls_data.is_space)
            begin
                if (b == 8'h22) begin
                    mode_next = M_STR; start_next = pos_inc; len_next = '0;
                end else if (cls_data.is_digit) begin
                    acc_next = 64'(cls_data.hex_val);
                    mode_next = (b == 8'h30) ? M_ZERO : M_DEC;
                end else if (cls_data.is_alpha || b == 8'h5F) begin
                    pref_next = '0;
                    pref_next[0] = b;
                    start_next = pos_reg;
                    len_next = OFFSET_BITS'(1);
                    mode_next = M_IDENT;
                end else if (b == 8'h3D) mode_next = M_EQ;
                else if (b == 8'h2D) mode_next = M_MINUS;
                else begin
                    if (n == 2'd0) begin
                        r0 = (cls_data.punct != 5'd0) ? mk(6'(cls_data.punct), E_NONE)
                                                     : mk(K_ERROR, E_CHAR);
                    end else begin
                        r1 = (cls_data.punct != 5'd0) ? mk(6'(cls_data.punct), E_NONE)
                                                     : mk(K_ERROR, E_CHAR);
                    end
                    n = n + 2'd1;
                    if (cls_data.punct == 5'd0) mode_next = M_ERR;
                end
            end
        end
        if (n == 2'd1) r0.last_of_run = 1'b1;
        if (n == 2'd2) r1.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            acc_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            pref_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            pref_reg  <= pref_next;
        end
    end

    // queue control: rd_reg points at head word
    logic pop;
    logic [1:0] cnt_after;
    assign pop = out_valid && out_ready;
    assign cnt_after = cnt_reg - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_after + (fire ? n : 2'd0);
            if (pop) rd_reg <= ~rd_reg;
        end
    end

    logic wr0;
    assign wr0 = rd_reg ^ pop ^ cnt_after[0];

    always_ff @(posedge clk)
    begin
        if (fire && n != 2'd0) q_reg[wr0] <= r0;
        if (fire && n == 2'd2) q_reg[~wr0] <= r1;
    end

    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = q_reg[rd_reg];
endmodule
`default_nettype wire

### rtl/source_text_tokenizer.sv
// Top level of the streaming source text tokenizer.
// Usage:
//  - in channel (in_valid/in_ready/in_data): one source byte per word, or an
//    end word (end_of_file=1) that flushes any pending token and emits Eof.
//  - out channel (out_valid/out_ready/out_data): token words; last_of_run
//    marks the final word caused by one input word.
//  - Path: input word -> front register -> back end -> output queue.
//  - Throughput: one byte per cycle while the output queue has room; a byte
//    that yields two words fills the two-entry queue; it drains one word a cycle.
//  - Reset: lexer returns to idle with position zero; output queue and front
//    register empty. When the receiver stalls, the output queue fills and the
//    back end, then the front register, hold off in_ready; no word is dropped.
`timescale 1ns / 1ps
`default_nettype none
module source_text_tokenizer #(
    parameter int OFFSET_BITS   = 32,
    parameter int KEYWORD_BYTES = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire stt_pkg::in_word_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output stt_pkg::out_word_t      out_data
);
    import stt_pkg::*;

    logic   cls_valid, cls_ready;
    class_t cls_data;

    stt_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .cls_valid(cls_valid), .cls_ready(cls_ready), .cls_data(cls_data)
    );

    stt_back #(.OFFSET_BITS(OFFSET_BITS), .KEYWORD_BYTES(KEYWORD_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cls_valid(cls_valid), .cls_ready(cls_ready), .cls_data(cls_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.token_kind <= K_ERROR)
        else $error("token kind out of range");
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_code != E_NONE |-> out_data.token_kind == K_ERROR)
        else $error("error code on non-error word");
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.token_kind == K_EOF |-> out_data.last_of_run)
        else $error("Eof not last of run");
endmodule
`default_nettype wire

### tb/tb_source_text_tokenizer.sv
// Testbench for source_text_tokenizer: directed table plus random token streams, scoreboarded.
`timescale 1ns / 1ps
`default_nettype none
module tb_source_text_tokenizer;
    import stt_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_WORDS = 1550;

    typedef enum int {
        LX_IDLE, LX_STR, LX_ZERO, LX_DEC, LX_HEX0, LX_HEX, LX_BIN0, LX_BIN,
        LX_OCT0, LX_OCT, LX_IDENT, LX_EQ, LX_MINUS, LX_ERR
    } lex_mode_e;

    typedef struct {
        logic [7:0] char_byte;
        logic       end_of_file;
        logic       has_check;   // typed-in first result below is valid
        logic [5:0] kind;
        logic [2:0] err;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_data;

    source_text_tokenizer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #1 clk = ~clk;

    // predictor state
    lex_mode_e   lx_mode;
    logic [63:0] lx_acc;
    logic [31:0] lx_start;
    logic [31:0] lx_len;
    logic [31:0] lx_pos;
    logic [7:0]  lx_prefix [8];

    out_word_t   expected_tokens[$];
    out_word_t   step_words[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          idle_enable = 1'b1;
    bit          hold_sink = 1'b0;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic bit is_space(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        if (is_digit(b)) return 5'(b - "0");
        if (b >= "a" && b <= "f") return 5'(b - "a" + 10);
        if (b >= "A" && b <= "F") return 5'(b - "A" + 10);
        return 5'd16;
    endfunction

    function automatic logic [5:0] punct_code(input logic [7:0] b);
        string p;
        p = "=:;.+-*/,(){}[]<>";
        for (int i = 0; i < 17; i++)
            if (p[i] == b) return 6'(i + 1);
        return 6'd0;
    endfunction

    function automatic void push_token(input logic [5:0] kind, input logic [63:0] val,
                                       input logic [31:0] st, input logic [31:0] ln,
                                       input logic [2:0] err);
        out_word_t w;
        w.token_kind = kind;
        w.number_value = val;
        w.text_start = st;
        w.text_length = ln;
        w.error_code = err;
        w.last_of_run = 1'b0;
        if (step_words.size() < 2) step_words.push_back(w);
    endfunction

    task automatic push_ident();
        string kw [11];
        bit same;
        kw = '{"var", "let", "function", "return", "if", "else", "while", "true",
               "false", "null", "enum"};
        for (int k = 0; k < 11; k++) begin
            if (lx_len != kw[k].len()) continue;
            same = 1'b1;
            for (int i = 0; i < kw[k].len(); i++)
                if (lx_prefix[i] != kw[k][i]) same = 1'b0;
            if (same) begin
                push_token(K_KW0 + 6'(k), '0, '0, '0, E_NONE);
                return;
            end
        end
        push_token(K_IDENT, '0, lx_start, lx_len, E_NONE);
    endtask

    task automatic lex_reset();
        lx_mode = LX_IDLE;
        lx_acc = '0;
        lx_start = '0;
        lx_len = '0;
        lx_pos = '0;
        foreach (lx_prefix[i]) lx_prefix[i] = '0;
    endtask

    task automatic lex_from_idle(input logic [7:0] b);
        logic [5:0] pk;
        pk = punct_code(b);
        if (is_space(b)) return;
        if (b == "\"") begin
            lx_mode = LX_STR;
            lx_start = sat_inc(lx_pos);
            lx_len = '0;
        end else if (is_digit(b)) begin
            lx_acc = 64'(b - "0");
            lx_mode = (b == "0") ? LX_ZERO : LX_DEC;
        end else if (is_alpha(b) || b == "_") begin
            foreach (lx_prefix[i]) lx_prefix[i] = '0;
            lx_prefix[0] = b;
            lx_start = lx_pos;
            lx_len = 32'd1;
            lx_mode = LX_IDENT;
        end else if (b == "=") lx_mode = LX_EQ;
        else if (b == "-") lx_mode = LX_MINUS;
        else if (pk != 0) push_token(pk, '0, '0, '0, E_NONE);
        else begin
            push_token(K_ERROR, '0, '0, '0, E_CHAR);
            lx_mode = LX_ERR;
        end
    endtask

    // returns 1 when the number ended and the byte must be re-lexed
    function automatic bit number_digit(input logic [4:0] d, input int base);
        if (d < base) begin
            lx_acc = lx_acc * 64'(base) + 64'(d);
            return 1'b0;
        end
        push_token(K_NUMBER, lx_acc, '0, '0, E_NONE);
        lx_mode = LX_IDLE;
        return 1'b1;
    endfunction

    task automatic predict_tokens(input in_word_t w);
        logic [7:0] b;
        logic [4:0] d;
        int base;
        bit again;
        b = w.char_byte;
        again = 1'b0;
        step_words.delete();
        if (w.end_of_file) begin
            case (lx_mode)
                LX_STR:  push_token(K_ERROR, '0, '0, '0, E_STRING);
                LX_HEX0: push_token(K_ERROR, '0, '0, '0, E_HEX);
                LX_BIN0: push_token(K_ERROR, '0, '0, '0, E_BIN);
                LX_OCT0: push_token(K_ERROR, '0, '0, '0, E_OCT);
                LX_ZERO, LX_DEC, LX_HEX, LX_BIN, LX_OCT:
                    push_token(K_NUMBER, lx_acc, '0, '0, E_NONE);
                LX_IDENT: push_ident();
                LX_EQ:    push_token(K_EQUALS, '0, '0, '0, E_NONE);
                LX_MINUS: push_token(K_MINUS, '0, '0, '0, E_NONE);
                default: ;
            endcase
            push_token(K_EOF, '0, '0, '0, E_NONE);
            lex_reset();
        end else begin
            case (lx_mode)
                LX_STR:
                    if (b == "\"") begin
                        push_token(K_STRING, '0, lx_start, lx_len, E_NONE);
                        lx_mode = LX_IDLE;
                    end else lx_len = sat_inc(lx_len);
                LX_ZERO:
                    if (b == "x" || b == "X") lx_mode = LX_HEX0;
                    else if (b == "b" || b == "B") lx_mode = LX_BIN0;
                    else if (b == "o" || b == "O") lx_mode = LX_OCT0;
                    else begin
                        lx_mode = LX_DEC;
                        again = number_digit(is_digit(b) ? 5'(b - "0") : 5'd16, 10);
                    end
                LX_DEC: again = number_digit(is_digit(b) ? 5'(b - "0") : 5'd16, 10);
                LX_HEX0, LX_BIN0, LX_OCT0: begin
                    base = (lx_mode == LX_HEX0) ? 16 : (lx_mode == LX_BIN0) ? 2 : 8;
                    d = hex_digit(b);
                    if (d < base) begin
                        lx_acc = 64'(d);
                        lx_mode = lex_mode_e'(int'(lx_mode) + 1);
                    end else begin
                        push_token(K_ERROR, '0, '0, '0,
                                   base == 16 ? E_HEX : base == 2 ? E_BIN : E_OCT);
                        lx_mode = LX_ERR;
                    end
                end
                LX_HEX: again = number_digit(hex_digit(b), 16);
                LX_BIN: again = number_digit(hex_digit(b), 2);
                LX_OCT: again = number_digit(hex_digit(b), 8);
                LX_IDENT:
                    if (is_alpha(b) || is_digit(b) || b == "_") begin
                        if (lx_len < 8) lx_prefix[lx_len[2:0]] = b;
                        lx_len = sat_inc(lx_len);
                    end else begin
                        push_ident();
                        lx_mode = LX_IDLE;
                        again = 1'b1;
                    end
                LX_EQ: begin
                    lx_mode = LX_IDLE;
                    if (b == "=") push_token(K_DEQ, '0, '0, '0, E_NONE);
                    else begin
                        push_token(K_EQUALS, '0, '0, '0, E_NONE);
                        again = 1'b1;
                    end
                end
                LX_MINUS: begin
                    lx_mode = LX_IDLE;
                    if (b == ">") push_token(K_ARROW, '0, '0, '0, E_NONE);
                    else begin
                        push_token(K_MINUS, '0, '0, '0, E_NONE);
                        again = 1'b1;
                    end
                end
                LX_ERR: ;
                default: again = 1'b1;
            endcase
            if (again) lex_from_idle(b);
            lx_pos = sat_inc(lx_pos);
        end
        if (step_words.size() > 0) step_words[step_words.size() - 1].last_of_run = 1'b1;
        foreach (step_words[i]) expected_tokens.push_back(step_words[i]);
    endtask

    // valid drops only for the length of a gap
    task automatic idle_gap();
        if (idle_enable && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // drive one word and wait for acceptance
    task automatic send_word(input logic [7:0] b, input logic eof);
        in_word_t w;
        w.char_byte = b;
        w.end_of_file = eof;
        idle_gap();
        in_data <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        predict_tokens(w);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    endtask

    // random token with random content: mostly well-formed, sometimes a stray byte or an end word
    task automatic send_random_token();
        string alnum, hex, punct;
        int n;
        alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        hex = "0123456789abcdefABCDEF";
        punct = "=:;.+-*/,(){}[]<>";
        case ($urandom_range(0, 11))
            0: begin
                send_word("\"", 1'b0);
                repeat ($urandom_range(0, 6)) send_word(8'($urandom_range(0, 255)) == "\""
                                                        ? 8'h41 : 8'($urandom_range(0, 255)), 1'b0);
                send_word("\"", 1'b0);
            end
            1: repeat ($urandom_range(1, 22)) send_word(8'($urandom_range("0", "9")), 1'b0);
            2: begin
                send_text($urandom_range(0, 1) ? "0x" : "0X");
                repeat ($urandom_range(1, 17)) send_word(hex[$urandom_range(0, 21)], 1'b0);
            end
            3: begin
                send_text($urandom_range(0, 1) ? "0b" : "0B");
                repeat ($urandom_range(1, 66)) send_word(8'($urandom_range("0", "1")), 1'b0);
            end
            4: begin
                send_text($urandom_range(0, 1) ? "0o" : "0O");
                repeat ($urandom_range(1, 8)) send_word(8'($urandom_range("0", "7")), 1'b0);
            end
            5: begin
                send_word(alnum[$urandom_range(0, 52)], 1'b0);
                n = $urandom_range(0, 11);
                repeat (n) send_word(alnum[$urandom_range(0, 62)], 1'b0);
            end
            6: begin
                string kws [11];
                kws = '{"var", "let", "function", "return", "if", "else", "while", "true",
                        "false", "null", "enum"};
                send_text(kws[$urandom_range(0, 10)]);
            end
            7: send_text($urandom_range(0, 1) ? "==" : "->");
            8: send_word(punct[$urandom_range(0, 16)], 1'b0);
            9: send_word(8'($urandom_range(0, 255)), 1'b0);
            10: send_word($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)), 1'b0);
            default: send_word(8'($urandom_range(0, 255)), 1'b1);
        endcase
        if ($urandom_range(0, 2) == 0) send_word(8'h20, 1'b0);
    endtask

    // receiver: random stalls, plus one long hold-off while the sender keeps going
    always @(posedge clk) begin
        if (rst_n) begin
            if (hold_sink) out_ready <= 1'b0;
            else if (idle_enable && $urandom_range(0, 7) == 0) out_ready <= 1'b0;
            else out_ready <= 1'b1;
        end
    end

    // one word moves on each out handshake
    always @(posedge clk) begin
        out_word_t exp_w;
        if (rst_n && out_valid && out_ready) begin
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected word, actual %p", $realtime, out_data);
                fail_count++;
            end else begin
                exp_w = expected_tokens.pop_front();
                if (out_data !== exp_w) begin
                    $display("%0t: mismatch, expected %p, actual %p",
                             $realtime, exp_w, out_data);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        stim_row_t dir_rows[$];
        dir_rows = '{
            '{8'h3B, 1'b0, 1'b1, 6'd3, E_NONE},
            '{8'h80, 1'b0, 1'b1, K_ERROR, E_CHAR},
            '{8'hFF, 1'b0, 1'b0, 6'd0, E_NONE},
            '{8'h00, 1'b1, 1'b1, K_EOF, E_NONE},
            '{"0", 1'b0, 1'b0, 6'd0, E_NONE},
            '{"x", 1'b0, 1'b0, 6'd0, E_NONE},
            '{"g", 1'b0, 1'b1, K_ERROR, E_HEX},
            '{8'h00, 1'b1, 1'b1, K_EOF, E_NONE},
            '{"0", 1'b0, 1'b0, 6'd0, E_NONE},
            '{"b", 1'b0, 1'b0, 6'd0, E_NONE},
            '{"2", 1'b0, 1'b1, K_ERROR, E_BIN},
            '{8'hFF, 1'b1, 1'b1, K_EOF, E_NONE},
            '{"0", 1'b0, 1'b0, 6'd0, E_NONE},
            '{"o", 1'b0, 1'b0, 6'd0, E_NONE},
            '{8'h00, 1'b1, 1'b1, K_ERROR, E_OCT},
            '{"\"", 1'b0, 1'b0, 6'd0, E_NONE},
            '{"q", 1'b0, 1'b0, 6'd0, E_NONE},
            '{8'h00, 1'b1, 1'b1, K_ERROR, E_STRING},
            '{"=", 1'b0, 1'b0, 6'd0, E_NONE},
            '{"=", 1'b0, 1'b1, K_DEQ, E_NONE},
            '{"-", 1'b0, 1'b0, 6'd0, E_NONE},
            '{">", 1'b0, 1'b1, K_ARROW, E_NONE},
            '{"-", 1'b0, 1'b0, 6'd0, E_NONE},
            '{8'h00, 1'b1, 1'b1, K_MINUS, E_NONE}
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        lex_reset();
        @(posedge clk);
        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].char_byte, dir_rows[i].end_of_file);
            if (dir_rows[i].has_check && (step_words.size() == 0 ||
                step_words[0].token_kind != dir_rows[i].kind ||
                step_words[0].error_code != dir_rows[i].err)) begin
                $display("%0t: table mismatch row %0d, expected kind %0d err %0d",
                         $realtime, i, dir_rows[i].kind, dir_rows[i].err);
                fail_count++;
            end
        end
        // long identifier, keyword with a tail, overflowing number
        send_text("function_x functio enum9 18446744073709551617 0xFFFFFFFFFFFFFFFFF ");
        send_word(8'h00, 1'b1);

        fork
            begin
                #200;
                hold_sink = 1'b1;
                repeat (120) @(posedge clk);
                hold_sink = 1'b0;
            end
        join_none

        for (int n = 0; n < RANDOM_WORDS; ) begin
            int pos_mark;
            pos_mark = lx_pos;
            if (n > RANDOM_WORDS - 200) idle_enable = 1'b0;
            send_random_token();
            n += (lx_pos > pos_mark) ? int'(lx_pos - pos_mark) : 4;
        end
        send_word(8'h00, 1'b1);
        in_valid <= 1'b0;

        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
